// ===== hdl/ocri_pkg.sv =====
// ----------------------------------------------------------------------------
// ocri_pkg
// Shared widths, register indexes, reset values and bundle types for the
// over-current retry integrator.
// ----------------------------------------------------------------------------
package ocri_pkg;

  // Field widths.
  localparam int STEP_WIDTH          = 16;
  localparam int LIMIT_WIDTH         = 24;
  localparam int RETRY_LEVEL_WIDTH   = 24;
  localparam int CFG_INDEX_WIDTH     = 2;
  localparam int CFG_DATA_WIDTH      = 24;
  localparam int LEVEL_WIDTH_DEFAULT = 24;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UP_STEP    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DOWN_STEP  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TRIP_LIMIT = 2'd2;

  // Configuration reset values.
  localparam logic [STEP_WIDTH-1:0]  UP_STEP_RESET    = 16'd65;
  localparam logic [STEP_WIDTH-1:0]  DOWN_STEP_RESET  = 16'd65;
  localparam logic [LIMIT_WIDTH-1:0] TRIP_LIMIT_RESET = 24'd65536;

  // Current configuration, as seen by the datapath.
  typedef struct packed {
    logic [STEP_WIDTH-1:0]  up_step;
    logic [STEP_WIDTH-1:0]  down_step;
    logic [LIMIT_WIDTH-1:0] trip_limit;
  } cfg_t;

  // One request: phase flags and gating conditions.
  typedef struct packed {
    logic phase_a_fault;
    logic phase_b_fault;
    logic phase_c_fault;
    logic clear_in_progress;
    logic sim_mode;
    logic bridge_sim_enable;
    logic init_done;
    logic feedback_disabled;
  } item_t;

  // One result.
  typedef struct packed {
    logic                         over_current_timeout;
    logic                         trip_phase_a;
    logic                         trip_phase_b;
    logic                         trip_phase_c;
    logic [RETRY_LEVEL_WIDTH-1:0] retry_level;
  } result_t;

endpackage

// ===== hdl/ocri_cfg.sv =====
// ----------------------------------------------------------------------------
// ocri_cfg
// Configuration register file: up step, down step and trip limit, written
// through a plain write port; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ocri_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ocri_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ocri_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output ocri_pkg::cfg_t                       cfg
);

  ocri_pkg::cfg_t regs;

  // Register writes; reset restores the default budget.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.up_step    <= ocri_pkg::UP_STEP_RESET;
      regs.down_step  <= ocri_pkg::DOWN_STEP_RESET;
      regs.trip_limit <= ocri_pkg::TRIP_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ocri_pkg::CFG_UP_STEP: begin
          regs.up_step <= cfg_data[ocri_pkg::STEP_WIDTH-1:0];
        end
        ocri_pkg::CFG_DOWN_STEP: begin
          regs.down_step <= cfg_data[ocri_pkg::STEP_WIDTH-1:0];
        end
        ocri_pkg::CFG_TRIP_LIMIT: begin
          regs.trip_limit <= cfg_data[ocri_pkg::LIMIT_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// ===== hdl/ocri_update.sv =====
// ----------------------------------------------------------------------------
// ocri_update
// One tick of the leaky level: qualify the phase flags, add or leak with
// saturation, then clamp at zero or at the trip limit.
// ----------------------------------------------------------------------------
module ocri_update #(
  parameter int LEVEL_WIDTH = ocri_pkg::LEVEL_WIDTH_DEFAULT
) (
  input  ocri_pkg::cfg_t         cfg,
  input  ocri_pkg::item_t        item,
  input  logic [LEVEL_WIDTH-1:0] level,
  input  logic                   timeout_flag,
  output logic [LEVEL_WIDTH-1:0] level_next,
  output ocri_pkg::result_t      result
);

  localparam int CMP_WIDTH =
    (LEVEL_WIDTH > ocri_pkg::LIMIT_WIDTH) ? LEVEL_WIDTH : ocri_pkg::LIMIT_WIDTH;

  logic                   gate;
  logic [2:0]             faults;
  logic [LEVEL_WIDTH:0]   sum;
  logic [LEVEL_WIDTH-1:0] up_level;
  logic [LEVEL_WIDTH-1:0] down_ext;
  logic [LEVEL_WIDTH-1:0] down_level;
  logic [LEVEL_WIDTH-1:0] raw_level;
  logic                   at_limit;
  logic                   timeout_next;
  logic [2:0]             trips;

  // Flags count only with no clear running, init done, feedback enabled,
  // and simulation either off or allowed to gate the bridge.
  assign gate = !item.clear_in_progress && (!item.sim_mode || item.bridge_sim_enable) &&
                item.init_done && !item.feedback_disabled;
  assign faults = {item.phase_a_fault, item.phase_b_fault, item.phase_c_fault} & {3{gate}};

  // Saturating add on a fault, flooring leak otherwise.
  assign sum        = {1'b0, level} + (LEVEL_WIDTH+1)'(cfg.up_step);
  assign up_level   = sum[LEVEL_WIDTH] ? '1 : sum[LEVEL_WIDTH-1:0];
  assign down_ext   = LEVEL_WIDTH'(cfg.down_step);
  assign down_level = (level > down_ext) ? (level - down_ext) : '0;
  assign raw_level  = (|faults) ? up_level : down_level;
  assign at_limit   = CMP_WIDTH'(raw_level) >= CMP_WIDTH'(cfg.trip_limit);

  // Zero wins over the limit; between the bounds the timeout holds.
  always_comb begin
    level_next   = raw_level;
    timeout_next = timeout_flag;
    trips        = '0;
    if (raw_level == '0) begin
      timeout_next = 1'b0;
    end else if (at_limit) begin
      level_next   = LEVEL_WIDTH'(cfg.trip_limit);
      timeout_next = 1'b1;
      trips        = faults;
    end
  end

  assign result.over_current_timeout = timeout_next;
  assign result.trip_phase_a         = trips[2];
  assign result.trip_phase_b         = trips[1];
  assign result.trip_phase_c         = trips[0];
  assign result.retry_level          = ocri_pkg::RETRY_LEVEL_WIDTH'(level_next);

endmodule

// ===== hdl/over_current_retry_integrator_core.sv =====
// ----------------------------------------------------------------------------
// over_current_retry_integrator_core
// Leaky-bucket integrator for recurrent instantaneous over-current trips.
// ----------------------------------------------------------------------------
// Usage:
// Each input request is one control tick: three phase fault flags and the
// gating conditions, on in_valid/in_ready. Each tick gives exactly one result
// on out_valid/out_ready: the timeout flag, per-phase trip pulses and the
// retry level after the tick.
// A request is held in an input register, then passes the update logic into
// the result register, where the level and timeout state are updated. One
// request is taken every cycle as long as results are taken; the throughput
// is set by the single level register that each tick reads and writes.
// While the receiver stalls, the held result and one more request in the
// input register are kept, so in_ready stays high until both are occupied.
// Reset (rst, synchronous) empties both registers, clears the level and the
// timeout flag and restores the configuration defaults. The user must write the
// cfg_we/cfg_index/cfg_data configuration while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module over_current_retry_integrator_core #(
  parameter int LEVEL_WIDTH = ocri_pkg::LEVEL_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [ocri_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [ocri_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  // Input channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   phase_a_fault,
  input  logic                                   phase_b_fault,
  input  logic                                   phase_c_fault,
  input  logic                                   clear_in_progress,
  input  logic                                   sim_mode,
  input  logic                                   bridge_sim_enable,
  input  logic                                   init_done,
  input  logic                                   feedback_disabled,
  // Output channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   over_current_timeout,
  output logic                                   trip_phase_a,
  output logic                                   trip_phase_b,
  output logic                                   trip_phase_c,
  output logic [ocri_pkg::RETRY_LEVEL_WIDTH-1:0] retry_level
);

  ocri_pkg::cfg_t         cfg;
  ocri_pkg::item_t        item_q;
  logic                   item_q_valid;
  logic                   advance;
  logic [LEVEL_WIDTH-1:0] level;
  logic [LEVEL_WIDTH-1:0] level_next;
  logic                   timeout_flag;
  ocri_pkg::result_t      result_next;
  ocri_pkg::result_t      result_q;

  ocri_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ocri_update #(
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_update (
    .cfg          (cfg),
    .item         (item_q),
    .level        (level),
    .timeout_flag (timeout_flag),
    .level_next   (level_next),
    .result       (result_next)
  );

  // A held request moves on whenever the result register is free or drains.
  assign advance  = item_q_valid && (!out_valid || out_ready);
  assign in_ready = !item_q_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (in_ready) begin
      item_q_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_q <= '{phase_a_fault:     phase_a_fault,
                  phase_b_fault:     phase_b_fault,
                  phase_c_fault:     phase_c_fault,
                  clear_in_progress: clear_in_progress,
                  sim_mode:          sim_mode,
                  bridge_sim_enable: bridge_sim_enable,
                  init_done:         init_done,
                  feedback_disabled: feedback_disabled};
    end
  end

  // Integrator state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      timeout_flag <= 1'b0;
      out_valid    <= 1'b0;
    end else if (advance) begin
      level        <= level_next;
      timeout_flag <= result_next.over_current_timeout;
      out_valid    <= 1'b1;
    end else if (out_ready) begin
      out_valid    <= 1'b0;
    end
    if (advance) begin
      result_q <= result_next;
    end
  end

  assign over_current_timeout = result_q.over_current_timeout;
  assign trip_phase_a         = result_q.trip_phase_a;
  assign trip_phase_b         = result_q.trip_phase_b;
  assign trip_phase_c         = result_q.trip_phase_c;
  assign retry_level          = result_q.retry_level;

  // A trip pulse only comes with the timeout set.
  a_trip_sets_timeout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (trip_phase_a || trip_phase_b || trip_phase_c)) |-> over_current_timeout)
    else $error("trip pulse without timeout");

  // The held result matches the timeout state it left behind.
  a_timeout_tracks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (over_current_timeout == timeout_flag))
    else $error("result timeout differs from state");

  // An empty input register always takes a request.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !item_q_valid |-> in_ready)
    else $error("input stage empty but not ready");

  // A request that moves on shows up as a valid result next cycle.
  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced request lost");

endmodule
